// ===== rtl/core/cba_pkg.sv =====
`default_nettype none

package cba_pkg;

    localparam int BLOCK_COUNT_DEF = 256;
    localparam int TABLE_DEPTH_DEF = 64;

    localparam int KEY_W   = 64;
    localparam int START_W = 8;
    localparam int LEN_W   = 9;
    localparam int CODE_W  = 3;
    localparam int IDX_W   = 8;

    // action codes
    localparam logic ACT_ALLOCATE = 1'b0;
    localparam logic ACT_LOOKUP   = 1'b1;

    // result status codes
    localparam logic [CODE_W-1:0] ST_ALLOCATED = 3'd0;
    localparam logic [CODE_W-1:0] ST_BUSY      = 3'd1;
    localparam logic [CODE_W-1:0] ST_BAD_RANGE = 3'd2;
    localparam logic [CODE_W-1:0] ST_FULL      = 3'd3;
    localparam logic [CODE_W-1:0] ST_FOUND     = 3'd3;
    localparam logic [CODE_W-1:0] ST_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic              load_item;
        logic              clr_wr;
        logic              idx_zero;
        logic              idx_inc;
        logic              map_rd;
        logic              map_set;
        logic              tbl_rd;
        logic              tbl_wr;
        logic              pend_take;
        logic              out_load;
        logic              out_pend;
        logic              out_last;
        logic [CODE_W-1:0] out_code;
    } cba_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic is_lookup;
        logic range_bad;
        logic map_used;
        logic run_last;
        logic scan_last;
        logic tbl_full;
        logic tbl_empty;
        logic key_match;
        logic pend_vld;
        logic out_free;
    } cba_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/cba_if.sv =====
`default_nettype none

interface cba_in_if;
    logic                         valid;
    logic                         ready;
    logic                         action;
    logic [cba_pkg::KEY_W-1:0]    file_key;
    logic [cba_pkg::START_W-1:0]  first_block;
    logic [cba_pkg::LEN_W-1:0]    run_length;

    modport source (output valid, action, file_key, first_block, run_length, input ready);
    modport sink   (input valid, action, file_key, first_block, run_length, output ready);
endinterface

interface cba_out_if;
    logic                         valid;
    logic                         ready;
    logic [cba_pkg::CODE_W-1:0]   status;
    logic [cba_pkg::START_W-1:0]  found_start;
    logic [cba_pkg::LEN_W-1:0]    found_length;
    logic                         last_result;

    modport source (output valid, status, found_start, found_length, last_result, input ready);
    modport sink   (input valid, status, found_start, found_length, last_result, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/contiguous_block_allocator.sv =====
// contiguous block allocator
// keeps a used/free bitmap of BLOCK_COUNT storage blocks and a table of up
// to TABLE_DEPTH files (key, start block, length)
// req channel: one transaction per item; action 0 allocates run_length
//   blocks from first_block, action 1 looks up file_key
// rsp channel: allocate gives one result (allocated, busy, bad range or
//   table full); lookup gives one found result per matching entry in table
//   order, last one flagged, or a single not-found result
// an allocate reads and checks its run block by block, then marks the
//   blocks one by one when granted; a lookup reads and checks the table
//   entry by entry; the bitmap and table take one access a cycle
// one item at a time: req.ready is high only while the block is idle
// reset: the bitmap is swept clear block by block after rst_n rises;
//   req.ready stays low during the sweep; the entry count resets to zero
// stall: results sit in an output register; while it is full and rsp.ready
//   is low, the scan holds at a match and the final result waits, nothing is dropped or repeated
`default_nettype none

module contiguous_block_allocator #(
    parameter int BLOCK_COUNT = cba_pkg::BLOCK_COUNT_DEF,
    parameter int TABLE_DEPTH = cba_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    cba_in_if.sink     req,
    cba_out_if.source  rsp
);

    cba_pkg::cba_cmd_t cmd;
    cba_pkg::cba_sts_t sts;
    logic              ctrl_ready;

    // sequencer: clear sweep, run check/mark, table scan
    cba_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (req.valid),
        .item_ready (ctrl_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    assign req.ready = ctrl_ready;

    // bitmap, file table, counters and result register
    cba_datapath #(
        .BLOCK_COUNT (BLOCK_COUNT),
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .item_action      (req.action),
        .item_file_key    (req.file_key),
        .item_first_block (req.first_block),
        .item_run_length  (req.run_length),
        .res_valid        (rsp.valid),
        .res_ready        (rsp.ready),
        .res_status       (rsp.status),
        .res_found_start  (rsp.found_start),
        .res_found_length (rsp.found_length),
        .res_last_result  (rsp.last_result)
    );

endmodule

`default_nettype wire

// ===== rtl/core/cba_datapath.sv =====
`default_nettype none

module cba_datapath #(
    parameter int BLOCK_COUNT = cba_pkg::BLOCK_COUNT_DEF,
    parameter int TABLE_DEPTH = cba_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire cba_pkg::cba_cmd_t            cmd,
    output cba_pkg::cba_sts_t                 sts,
    input  wire logic                         item_action,
    input  wire logic [cba_pkg::KEY_W-1:0]    item_file_key,
    input  wire logic [cba_pkg::START_W-1:0]  item_first_block,
    input  wire logic [cba_pkg::LEN_W-1:0]    item_run_length,
    output logic                              res_valid,
    input  wire logic                         res_ready,
    output logic [cba_pkg::CODE_W-1:0]        res_status,
    output logic [cba_pkg::START_W-1:0]       res_found_start,
    output logic [cba_pkg::LEN_W-1:0]         res_found_length,
    output logic                              res_last_result
);

    localparam int MAP_AW = $clog2(BLOCK_COUNT);
    localparam int TBL_AW = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int SUM_W  = ($clog2(BLOCK_COUNT + 1) > 10) ? $clog2(BLOCK_COUNT + 1) : 10;
    localparam int ENT_W  = cba_pkg::KEY_W + cba_pkg::START_W + cba_pkg::LEN_W;

    // captured item
    logic                         action_reg;
    logic [cba_pkg::KEY_W-1:0]    key_reg;
    logic [cba_pkg::START_W-1:0]  first_reg;
    logic [cba_pkg::LEN_W-1:0]    len_reg;

    logic [cba_pkg::IDX_W-1:0]    idx_reg, idx_next;
    logic [MAP_AW-1:0]            clr_idx_reg, clr_idx_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;

    // used/free bitmap and file table
    logic                         used_map [BLOCK_COUNT];
    logic                         map_q_reg;
    logic [ENT_W-1:0]             entry_tbl [TABLE_DEPTH];
    logic [ENT_W-1:0]             ent_q_reg;

    logic                         pend_vld_reg, pend_vld_next;
    logic [cba_pkg::START_W-1:0]  pend_start_reg;
    logic [cba_pkg::LEN_W-1:0]    pend_len_reg;

    logic                         out_valid_reg, out_valid_next;
    logic [cba_pkg::CODE_W-1:0]   out_status_reg;
    logic [cba_pkg::START_W-1:0]  out_start_reg;
    logic [cba_pkg::LEN_W-1:0]    out_len_reg;
    logic                         out_last_reg;

    logic [cba_pkg::LEN_W-1:0]    run_sum;
    logic [MAP_AW-1:0]            run_addr;
    logic [MAP_AW-1:0]            map_wa;
    logic [SUM_W-1:0]             run_end;
    logic                         out_free;
    logic [cba_pkg::KEY_W-1:0]    ent_key;
    logic [cba_pkg::START_W-1:0]  ent_start;
    logic [cba_pkg::LEN_W-1:0]    ent_len;

    assign run_sum  = {1'b0, first_reg} + cba_pkg::LEN_W'(idx_reg);
    assign run_addr = MAP_AW'(run_sum);
    assign map_wa   = cmd.clr_wr ? clr_idx_reg : run_addr;
    assign run_end  = SUM_W'(first_reg) + SUM_W'(len_reg);
    assign out_free = !out_valid_reg || res_ready;
    assign {ent_key, ent_start, ent_len} = ent_q_reg;

    always_comb
    begin
        sts.clr_done  = (clr_idx_reg == MAP_AW'(BLOCK_COUNT - 1));
        sts.is_lookup = (action_reg == cba_pkg::ACT_LOOKUP);
        sts.range_bad = (len_reg == '0) || (run_end > SUM_W'(BLOCK_COUNT));
        sts.map_used  = map_q_reg;
        sts.run_last  = (cba_pkg::LEN_W'(idx_reg) + cba_pkg::LEN_W'(1)) == len_reg;
        sts.scan_last = (cba_pkg::LEN_W'(idx_reg) + cba_pkg::LEN_W'(1))
                        == cba_pkg::LEN_W'(cnt_reg);
        sts.tbl_full  = (cnt_reg == CNT_W'(TABLE_DEPTH));
        sts.tbl_empty = (cnt_reg == '0);
        sts.key_match = (ent_key == key_reg);
        sts.pend_vld  = pend_vld_reg;
        sts.out_free  = out_free;
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.idx_zero)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + cba_pkg::IDX_W'(1);
        end
        clr_idx_next = cmd.clr_wr ? clr_idx_reg + MAP_AW'(1) : clr_idx_reg;
        cnt_next     = cmd.tbl_wr ? cnt_reg + CNT_W'(1) : cnt_reg;
        pend_vld_next = pend_vld_reg;
        if (cmd.load_item)
        begin
            pend_vld_next = 1'b0;
        end
        else if (cmd.pend_take)
        begin
            pend_vld_next = 1'b1;
        end
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            clr_idx_reg   <= '0;
            cnt_reg       <= '0;
            pend_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            clr_idx_reg   <= clr_idx_next;
            cnt_reg       <= cnt_next;
            pend_vld_reg  <= pend_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            action_reg <= item_action;
            key_reg    <= item_file_key;
            first_reg  <= item_first_block;
            len_reg    <= item_run_length;
        end
        if (cmd.pend_take)
        begin
            pend_start_reg <= ent_start;
            pend_len_reg   <= ent_len;
        end
        if (cmd.out_load)
        begin
            out_last_reg <= cmd.out_last;
            if (cmd.out_pend)
            begin
                out_status_reg <= cba_pkg::ST_FOUND;
                out_start_reg  <= pend_start_reg;
                out_len_reg    <= pend_len_reg;
            end
            else
            begin
                out_status_reg <= cmd.out_code;
                out_start_reg  <= '0;
                out_len_reg    <= '0;
            end
        end
    end

    // bitmap: one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.clr_wr || cmd.map_set)
        begin
            used_map[map_wa] <= cmd.map_set && !cmd.clr_wr;
        end
        if (cmd.map_rd)
        begin
            map_q_reg <= used_map[run_addr];
        end
    end

    // file table: append at entry count, scan by index
    always_ff @(posedge clk)
    begin
        if (cmd.tbl_wr)
        begin
            entry_tbl[cnt_reg[TBL_AW-1:0]] <= {key_reg, first_reg, len_reg};
        end
        if (cmd.tbl_rd)
        begin
            ent_q_reg <= entry_tbl[idx_reg[TBL_AW-1:0]];
        end
    end

    assign res_valid        = out_valid_reg;
    assign res_status       = out_status_reg;
    assign res_found_start  = out_start_reg;
    assign res_found_length = out_len_reg;
    assign res_last_result  = out_last_reg;

    a_tbl_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tbl_wr |-> (cnt_reg < CNT_W'(TABLE_DEPTH)))
        else $error("table append with no room");

    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> out_free)
        else $error("result overwritten before transaction");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count past table depth");

endmodule

`default_nettype wire

// ===== rtl/core/cba_ctrl.sv =====
`default_nettype none

module cba_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_ready,
    input  wire cba_pkg::cba_sts_t sts,
    output cba_pkg::cba_cmd_t      cmd
);

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_DECODE = 9'b000000100,
        S_A_RD   = 9'b000001000,
        S_A_CHK  = 9'b000010000,
        S_A_SET  = 9'b000100000,
        S_L_RD   = 9'b001000000,
        S_L_CHK  = 9'b010000000,
        S_RESP   = 9'b100000000
    } state_t;

    state_t                       state_reg, state_next;
    logic [cba_pkg::CODE_W-1:0]   code_reg, code_next;

    assign item_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.idx_zero = 1'b1;
                if (sts.is_lookup)
                begin
                    if (sts.tbl_empty)
                    begin
                        code_next  = cba_pkg::ST_NOT_FOUND;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        state_next = S_L_RD;
                    end
                end
                else if (sts.range_bad)
                begin
                    code_next  = cba_pkg::ST_BAD_RANGE;
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_A_RD;
                end
            end
            S_A_RD:
            begin
                cmd.map_rd = 1'b1;
                state_next = S_A_CHK;
            end
            S_A_CHK:
            begin
                if (sts.map_used)
                begin
                    code_next  = cba_pkg::ST_BUSY;
                    state_next = S_RESP;
                end
                else if (sts.run_last)
                begin
                    if (sts.tbl_full)
                    begin
                        code_next  = cba_pkg::ST_FULL;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        cmd.idx_zero = 1'b1;
                        state_next   = S_A_SET;
                    end
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_A_RD;
                end
            end
            S_A_SET:
            begin
                cmd.map_set = 1'b1;
                if (sts.run_last)
                begin
                    cmd.tbl_wr = 1'b1;
                    code_next  = cba_pkg::ST_ALLOCATED;
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_L_RD:
            begin
                cmd.tbl_rd = 1'b1;
                state_next = S_L_CHK;
            end
            S_L_CHK:
            begin
                // a held match goes out once a newer one shows it is not last, or as last at scan end
                if (!(sts.key_match && sts.pend_vld && !sts.out_free))
                begin
                    if (sts.key_match)
                    begin
                        cmd.pend_take = 1'b1;
                        if (sts.pend_vld)
                        begin
                            cmd.out_load = 1'b1;
                            cmd.out_pend = 1'b1;
                        end
                    end
                    if (sts.scan_last)
                    begin
                        code_next  = cba_pkg::ST_NOT_FOUND;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_L_RD;
                    end
                end
            end
            S_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_pend = sts.pend_vld;
                    cmd.out_last = 1'b1;
                    cmd.out_code = code_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            code_reg  <= cba_pkg::ST_ALLOCATED;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && cmd.out_last) |=> (state_reg == S_IDLE))
        else $error("final result not followed by idle");

endmodule

`default_nettype wire

// ===== tb/sv/tb_contiguous_block_allocator.sv =====
`timescale 1ns / 100ps

module tb_contiguous_block_allocator;

    import cba_pkg::*;

    localparam int BLOCKS      = BLOCK_COUNT_DEF;
    localparam int ENTRIES     = TABLE_DEPTH_DEF;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 1000;

    // one request transaction as the block sees it
    typedef struct packed {
        logic               action;
        logic [KEY_W-1:0]   file_key;
        logic [START_W-1:0] first_block;
        logic [LEN_W-1:0]   run_length;
    } alloc_request_t;

    // one response transaction
    typedef struct packed {
        logic [CODE_W-1:0]  status;
        logic [START_W-1:0] found_start;
        logic [LEN_W-1:0]   found_length;
        logic               last_result;
    } alloc_result_t;

    // how the two sides idle in the current stretch of the run
    typedef enum logic [2:0] {
        MODE_STEADY,
        MODE_HOLD,
        MODE_SEND_IDLE,
        MODE_RECV_STALL,
        MODE_BOTH_IDLE
    } traffic_mode_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // tb-side copies of every block input, known from time zero
    logic               in_valid  = 1'b0;
    logic               in_action = ACT_ALLOCATE;
    logic [KEY_W-1:0]   in_key    = '0;
    logic [START_W-1:0] in_first  = '0;
    logic [LEN_W-1:0]   in_length = '0;
    logic               out_ready = 1'b0;

    traffic_mode_t traffic_mode = MODE_STEADY;
    int            fail_count   = 0;
    int            hold_left;
    logic          hold_taken;

    // requests not yet accepted, head is the one on the bus
    alloc_request_t request_queue[$];
    // responses predicted for accepted requests, oldest first
    alloc_result_t  awaited_results[$];

    // shadow of the allocator state
    logic [BLOCKS-1:0]  shadow_used;
    logic [KEY_W-1:0]   shadow_keys[ENTRIES];
    logic [START_W-1:0] shadow_starts[ENTRIES];
    logic [LEN_W-1:0]   shadow_lengths[ENTRIES];
    int                 shadow_count;

    // stimulus planning state
    logic [KEY_W-1:0] key_pool[5];
    int               alloc_cursor;

    cba_in_if  req();
    cba_out_if rsp();

    assign req.valid       = in_valid;
    assign req.action      = in_action;
    assign req.file_key    = in_key;
    assign req.first_block = in_first;
    assign req.run_length  = in_length;
    assign rsp.ready       = out_ready;

    contiguous_block_allocator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // fixed upper bound on the whole run
    initial
    begin
        #100_000_000;
        $display("%0t: timeout, responses still awaited: %0d", $time, awaited_results.size());
        $display("Test completed with failures");
        $finish;
    end

    // work out the responses that one accepted request must produce and
    // update the shadow state the same way the block does
    task automatic predict_outcome(input alloc_request_t r);
        logic busy;
        int   hits;
        busy = 1'b0;
        hits = 0;
        if (r.action == ACT_ALLOCATE)
        begin
            if (r.run_length == 0 || int'(r.first_block) + int'(r.run_length) > BLOCKS)
            begin
                awaited_results.push_back(alloc_result_t'{ST_BAD_RANGE, '0, '0, 1'b1});
            end
            else
            begin
                for (int i = 0; i < int'(r.run_length); i++)
                    if (shadow_used[int'(r.first_block) + i])
                        busy = 1'b1;
                if (busy)
                    awaited_results.push_back(alloc_result_t'{ST_BUSY, '0, '0, 1'b1});
                else if (shadow_count >= ENTRIES)
                    awaited_results.push_back(alloc_result_t'{ST_FULL, '0, '0, 1'b1});
                else
                begin
                    // grant: mark the run and record the file
                    for (int i = 0; i < int'(r.run_length); i++)
                        shadow_used[int'(r.first_block) + i] = 1'b1;
                    shadow_keys[shadow_count]    = r.file_key;
                    shadow_starts[shadow_count]  = r.first_block;
                    shadow_lengths[shadow_count] = r.run_length;
                    shadow_count++;
                    awaited_results.push_back(alloc_result_t'{ST_ALLOCATED, '0, '0, 1'b1});
                end
            end
        end
        else
        begin
            // every matching entry in table order, duplicates included
            for (int i = 0; i < shadow_count; i++)
            begin
                if (shadow_keys[i] == r.file_key)
                begin
                    awaited_results.push_back(alloc_result_t'{ST_FOUND, shadow_starts[i],
                                                              shadow_lengths[i], 1'b0});
                    hits++;
                end
            end
            if (hits == 0)
                awaited_results.push_back(alloc_result_t'{ST_NOT_FOUND, '0, '0, 1'b1});
            else
                awaited_results[awaited_results.size() - 1].last_result = 1'b1;
        end
    endtask

    // request driver: holds a transaction until accepted, then predicts it
    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        alloc_request_t taken;
        alloc_request_t upcoming;
        logic           sender_idle;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && req.ready)
            begin
                taken = request_queue.pop_front();
                predict_outcome(taken);
            end
            sender_idle = (traffic_mode == MODE_SEND_IDLE && $urandom_range(0, 99) < 86) ||
                          (traffic_mode == MODE_BOTH_IDLE && $urandom_range(0, 99) < 35);
            if (in_valid && !req.ready)
            begin
                // not yet accepted: keep the transaction on the bus
            end
            else if (request_queue.size() != 0 && !sender_idle)
            begin
                upcoming  = request_queue[0];
                in_valid  <= 1'b1;
                in_action <= upcoming.action;
                in_key    <= upcoming.file_key;
                in_first  <= upcoming.first_block;
                in_length <= upcoming.run_length;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, counted here, armed once when the hold stretch starts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left  <= 0;
            hold_taken <= 1'b0;
        end
        else if (traffic_mode == MODE_HOLD && !hold_taken)
        begin
            hold_left  <= HOLD_CYCLES;
            hold_taken <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // response monitor: checks each accepted transaction against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : check_responses
        alloc_result_t want;
        logic          stall;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (rsp.valid && out_ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: unexpected response status=%0d start=%0d length=%0d last=%0b",
                             $time, rsp.status, rsp.found_start, rsp.found_length,
                             rsp.last_result);
                    fail_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (rsp.status !== want.status || rsp.found_start !== want.found_start ||
                        rsp.found_length !== want.found_length ||
                        rsp.last_result !== want.last_result)
                    begin
                        $display("%0t: mismatch expected status=%0d start=%0d length=%0d last=%0b",
                                 $time, want.status, want.found_start, want.found_length,
                                 want.last_result);
                        $display("%0t:          actual   status=%0d start=%0d length=%0d last=%0b",
                                 $time, rsp.status, rsp.found_start, rsp.found_length,
                                 rsp.last_result);
                        fail_count++;
                    end
                end
            end
            stall = (hold_left != 0) ||
                    (traffic_mode == MODE_RECV_STALL && $urandom_range(0, 99) < 86) ||
                    (traffic_mode == MODE_BOTH_IDLE && $urandom_range(0, 99) < 35);
            out_ready <= !stall;
        end
    end

    task automatic queue_request(input logic action, input logic [KEY_W-1:0] key,
                                 input int first, input int length);
        request_queue.push_back(alloc_request_t'{action, key, START_W'(first), LEN_W'(length)});
    endtask

    // mostly well-formed allocations walking up the store with pooled keys,
    // lookups that usually hit, and some random allocations as noise
    task automatic queue_random_requests(input int count);
        int kind;
        int length;
        for (int n = 0; n < count; n++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 45 && alloc_cursor < BLOCKS)
            begin
                length = ($urandom_range(0, 19) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
                if (alloc_cursor + length > BLOCKS)
                    length = BLOCKS - alloc_cursor;
                queue_request(ACT_ALLOCATE, key_pool[$urandom_range(0, 4)], alloc_cursor, length);
                alloc_cursor += length;
            end
            else if (kind < 80 || alloc_cursor >= BLOCKS && kind < 45)
            begin
                if ($urandom_range(0, 99) < 85)
                    queue_request(ACT_LOOKUP, key_pool[$urandom_range(0, 4)],
                                  $urandom_range(0, 255), $urandom_range(0, 256));
                else
                    queue_request(ACT_LOOKUP, {$urandom, $urandom},
                                  $urandom_range(0, 255), $urandom_range(0, 256));
            end
            else
            begin
                length = $urandom_range(0, 1) ? $urandom_range(0, 256) : $urandom_range(0, 4);
                queue_request(ACT_ALLOCATE, {$urandom, $urandom}, $urandom_range(0, 255), length);
            end
        end
    endtask

    // every queued transaction accepted and every predicted response seen
    task automatic wait_for_drain();
        while (request_queue.size() != 0 || awaited_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        shadow_used  = '0;
        shadow_count = 0;
        for (int i = 0; i < 5; i++)
            key_pool[i] = {$urandom, $urandom};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed opening: empty table, range edges, busy overlap, duplicates
        queue_request(ACT_LOOKUP, '0, 0, 0);                  // lookup before any file
        queue_request(ACT_ALLOCATE, key_pool[1], 0, 0);       // empty run
        queue_request(ACT_ALLOCATE, key_pool[1], 255, 2);     // runs past the last block
        queue_request(ACT_ALLOCATE, key_pool[1], 1, 256);     // full length off by one
        queue_request(ACT_ALLOCATE, '1, 255, 1);              // last block alone
        queue_request(ACT_ALLOCATE, key_pool[0], 0, 4);
        queue_request(ACT_ALLOCATE, key_pool[2], 2, 3);       // overlaps the run above
        queue_request(ACT_ALLOCATE, key_pool[2], 0, 256);     // whole store, partly used
        queue_request(ACT_ALLOCATE, key_pool[0], 4, 2);       // duplicate key
        queue_request(ACT_ALLOCATE, key_pool[3], 254, 2);     // good range, last block used
        queue_request(ACT_LOOKUP, key_pool[0], 0, 0);         // two matches
        queue_request(ACT_LOOKUP, '1, 255, 256);              // single match
        queue_request(ACT_LOOKUP, '0, 0, 0);                  // still nothing under zero
        queue_request(ACT_LOOKUP, key_pool[3], 0, 0);         // rejected file not recorded
        alloc_cursor = 6;
        wait_for_drain();

        @(negedge clk);
        queue_random_requests(100);
        wait_for_drain();

        // receiver held off while the sender keeps offering
        @(negedge clk);
        traffic_mode = MODE_HOLD;
        queue_random_requests(15);
        wait_for_drain();

        @(negedge clk);
        traffic_mode = MODE_SEND_IDLE;
        queue_random_requests(100);
        wait_for_drain();

        @(negedge clk);
        traffic_mode = MODE_RECV_STALL;
        queue_random_requests(100);
        wait_for_drain();

        @(negedge clk);
        traffic_mode = MODE_BOTH_IDLE;
        queue_random_requests(105);
        wait_for_drain();

        // let any stray response show up before judging
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
